[hdl/nlsc_pkg.sv]
// ----------------------------------------------------------------------------
// nlsc_pkg
// Types and constants shared by the nested literal syntax checker and its
// stack cells.
// ----------------------------------------------------------------------------
package nlsc_pkg;

    localparam int LEVEL_W = 7;

    typedef logic [1:0] t_br;
    localparam t_br BR_LIST  = 2'd0;
    localparam t_br BR_TUPLE = 2'd1;
    localparam t_br BR_ANGLE = 2'd2;
    localparam t_br BR_DICT  = 2'd3;

    typedef logic [1:0] t_status;
    localparam t_status ST_VALID  = 2'd0;
    localparam t_status ST_ACCEPT = 2'd1;
    localparam t_status ST_REJECT = 2'd2;

    typedef enum logic [4:0] {
        POS_B = 5'b00001,
        POS_E = 5'b00010,
        POS_K = 5'b00100,
        POS_M = 5'b01000,
        POS_V = 5'b10000
    } t_pos;

    typedef enum logic [2:0] {
        TOK_NONE = 3'b001,
        TOK_NUM  = 3'b010,
        TOK_STR  = 3'b100
    } t_tok;

    typedef struct packed {
        t_br  br;
        logic side;
    } t_entry;

    typedef struct packed {
        logic push;
        logic pop;
        logic flag_we;
        logic flag_val;
    } t_stk_ctl;

endpackage

[hdl/nlsc_cell.sv]
// ----------------------------------------------------------------------------
// nlsc_cell
// One level of the shifting bracket stack: takes its upper neighbor on a
// push, its lower neighbor on a pop, and updates its side flag on request.
// ----------------------------------------------------------------------------
module nlsc_cell import nlsc_pkg::*; (
    input  logic     i_clk,
    input  t_stk_ctl i_ctl,
    input  t_entry   i_prev,
    input  t_entry   i_next,
    output t_entry   o_entry
);

    t_entry r_entry;
    t_entry n_entry;

    always_comb begin
        n_entry = r_entry;
        if (i_ctl.push) begin
            n_entry = i_prev;
        end else if (i_ctl.pop) begin
            n_entry = i_next;
        end else if (i_ctl.flag_we) begin
            n_entry.side = i_ctl.flag_val;
        end
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
    end

    assign o_entry = r_entry;

endmodule

[hdl/nested_literal_syntax_checker.sv]
// ----------------------------------------------------------------------------
// nested_literal_syntax_checker
// Streaming syntax checker for nested list, tuple, angle and dict literals.
// ----------------------------------------------------------------------------
// One character or end beat is taken every clock cycle while o_in_ready is
// high; each gives one result beat in the next cycle via the output register;
// this rate rests on the stack top update in cell 0 and the small parser
// state. The bracket stack is a row of MAX_DEPTH cells that shift down on an
// open and up on a close, so the top is always at cell 0. An end beat reports
// accept or reject and returns the checker to its reset state.
module nested_literal_syntax_checker import nlsc_pkg::*; #(
    parameter int MAX_DEPTH = 64
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  logic                i_kind,
    input  logic [7:0]          i_ch,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output logic [1:0]          o_status,
    output logic [LEVEL_W-1:0]  o_level
);

    localparam int LW = $clog2(MAX_DEPTH + 1);

    logic [LW-1:0] r_level, n_level;
    t_pos          r_pos, n_pos;
    t_tok          r_tok, n_tok;
    logic          r_dq, n_dq;
    logic          r_failed, n_failed;

    logic          r_out_valid;
    t_status       r_status;
    logic [LEVEL_W-1:0] r_olevel;

    t_entry        cells [MAX_DEPTH];
    t_stk_ctl      ctl;
    t_stk_ctl      ctl_rest;
    t_entry        push_entry;

    logic          acc;
    logic          is_num;
    logic          has_top;
    t_entry        top;
    t_pos          p;
    logic          go_out;
    logic          ok_end;
    logic          value_ok, scalar_ok, close_ok, comma_ok, colon_ok;
    logic          is_op, is_cl;
    t_br           op, cl;
    logic [7:0]    q;

    assign acc        = i_in_valid && o_in_ready;
    assign o_in_ready = !r_out_valid || i_out_ready;

    assign is_num  = (i_ch == "-") || (i_ch == ".") || (i_ch >= "0" && i_ch <= "9");
    assign has_top = (r_level != '0);
    assign top     = cells[0];
    assign q       = r_dq ? 8'h22 : 8'h27;
    assign ok_end  = !r_failed && (r_tok != TOK_STR) && (r_level == '0);

    always_comb begin
        is_op = 1'b1;
        op    = BR_LIST;
        case (i_ch)
            "[":     op = BR_LIST;
            "(":     op = BR_TUPLE;
            "<":     op = BR_ANGLE;
            "{":     op = BR_DICT;
            default: is_op = 1'b0;
        endcase
        is_cl = 1'b1;
        cl    = BR_LIST;
        case (i_ch)
            "]":     cl = BR_LIST;
            ")":     cl = BR_TUPLE;
            ">":     cl = BR_ANGLE;
            "}":     cl = BR_DICT;
            default: is_cl = 1'b0;
        endcase
    end

    always_comb begin
        n_level    = r_level;
        n_pos      = r_pos;
        n_tok      = r_tok;
        n_dq       = r_dq;
        n_failed   = r_failed;
        ctl        = '0;
        push_entry = '{br: op, side: 1'b0};
        go_out     = 1'b0;
        p          = r_pos;
        value_ok   = 1'b0;
        scalar_ok  = 1'b0;
        close_ok   = 1'b0;
        comma_ok   = 1'b0;
        colon_ok   = 1'b0;

        if (i_kind) begin
            n_level  = '0;
            n_pos    = POS_B;
            n_tok    = TOK_NONE;
            n_dq     = 1'b0;
            n_failed = 1'b0;
        end else if (!r_failed) begin
            // finish of a scalar picks the next position from the top level
            if (has_top && top.br == BR_DICT) begin
                p = top.side ? POS_E : POS_M;
            end else begin
                p = POS_E;
            end
            case (r_tok)
                TOK_STR: begin
                    if (i_ch == q) begin
                        n_tok = TOK_NONE;
                        n_pos = p;
                    end
                    p = r_pos;
                end
                TOK_NUM: begin
                    if (!is_num) begin
                        n_tok  = TOK_NONE;
                        n_pos  = p;
                        go_out = 1'b1;
                    end
                end
                default: begin
                    p      = r_pos;
                    go_out = 1'b1;
                end
            endcase

            if (go_out && !(i_ch <= 8'd32 || i_ch == 8'd127)) begin
                if (!has_top) begin
                    value_ok = (p == POS_B);
                end else if (top.br != BR_DICT) begin
                    value_ok = (p == POS_B);
                    close_ok = (p == POS_B) || (p == POS_E);
                    comma_ok = (p == POS_E);
                end else begin
                    scalar_ok = (p == POS_K);
                    close_ok  = (p == POS_K) || (p == POS_E);
                    colon_ok  = (p == POS_M);
                    value_ok  = (p == POS_V);
                    comma_ok  = (p == POS_E);
                end
                scalar_ok = scalar_ok || value_ok;

                if (is_op && value_ok) begin
                    if (r_level >= LW'(MAX_DEPTH)) begin
                        n_failed = 1'b1;
                    end else begin
                        ctl.push = 1'b1;
                        n_level  = r_level + 1'b1;
                        n_pos    = (op == BR_DICT) ? POS_K : POS_B;
                    end
                end else if (is_num && scalar_ok) begin
                    n_tok = TOK_NUM;
                end else if ((i_ch == 8'h22 || i_ch == 8'h27) && scalar_ok) begin
                    n_tok = TOK_STR;
                    n_dq  = (i_ch == 8'h22);
                end else if (is_cl && close_ok && cl == top.br) begin
                    ctl.pop = 1'b1;
                    n_level = r_level - 1'b1;
                    n_pos   = POS_E;
                end else if (i_ch == "," && comma_ok) begin
                    if (top.br == BR_DICT) begin
                        ctl.flag_we  = 1'b1;
                        ctl.flag_val = 1'b0;
                        n_pos        = POS_K;
                    end else begin
                        n_pos = POS_B;
                    end
                end else if (i_ch == ":" && colon_ok) begin
                    ctl.flag_we  = 1'b1;
                    ctl.flag_val = 1'b1;
                    n_pos        = POS_V;
                end else begin
                    n_failed = 1'b1;
                end
            end
        end

        if (!acc) begin
            ctl = '0;
        end
    end

    always_comb begin
        ctl_rest         = ctl;
        ctl_rest.flag_we = 1'b0;
    end

    genvar gi;
    generate
        for (gi = 0; gi < MAX_DEPTH; gi++) begin : g_cell
            t_entry prev_e;
            t_entry next_e;
            if (gi == 0) begin : g_top
                assign prev_e = push_entry;
            end else begin : g_mid
                assign prev_e = cells[gi-1];
            end
            if (gi == MAX_DEPTH - 1) begin : g_last
                assign next_e = '0;
            end else begin : g_inner
                assign next_e = cells[gi+1];
            end
            nlsc_cell u_cell (
                .i_clk   (i_clk),
                .i_ctl   ((gi == 0) ? ctl : ctl_rest),
                .i_prev  (prev_e),
                .i_next  (next_e),
                .o_entry (cells[gi])
            );
        end
    endgenerate

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_level     <= '0;
            r_pos       <= POS_B;
            r_tok       <= TOK_NONE;
            r_dq        <= 1'b0;
            r_failed    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (acc) begin
                r_level  <= n_level;
                r_pos    <= n_pos;
                r_tok    <= n_tok;
                r_dq     <= n_dq;
                r_failed <= n_failed;
            end
            if (acc) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc) begin
            if (i_kind) begin
                r_status <= ok_end ? ST_ACCEPT : ST_REJECT;
            end else begin
                r_status <= n_failed ? ST_REJECT : ST_VALID;
            end
            r_olevel <= LEVEL_W'(n_level);
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_status    = r_status;
    assign o_level     = r_olevel;

    a_end_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        acc && i_kind |=> (r_level == '0) && !r_failed && (r_tok == TOK_NONE))
        else $error("end beat did not clear the checker state");

    a_failed_frozen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        acc && !i_kind && r_failed |=> $stable(r_level) && r_failed)
        else $error("state moved after an error");

    a_depth_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_level <= LW'(MAX_DEPTH))
        else $error("nesting level beyond stack depth");

    a_accept_level: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_status == ST_ACCEPT |-> o_level == '0)
        else $error("accept reported with open containers");

endmodule
